// File: rtl/core/tlspq_pkg.sv
package tlspq_pkg;

    localparam int TLSPQ_DEPTH = 16;
    localparam int ID_W        = 10;
    localparam int LVL_W       = 2;
    localparam int CMD_W       = 2;
    localparam int STAT_W      = 2;

    // commands on the request channel
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DRAIN  = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd2;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd3;

    // levels
    localparam logic [LVL_W-1:0] LVL_MIN = 2'd1;

    // cell operation codes, broadcast to every cell
    localparam logic [1:0] OP_HOLD   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_SHIFT  = 2'd3;

    typedef struct packed {
        logic [1:0]       mode;
        logic [ID_W-1:0]  key;
        logic [LVL_W-1:0] lvl;
    } tlspq_op_t;

    typedef struct packed {
        logic             valid;
        logic [ID_W-1:0]  id;
        logic [LVL_W-1:0] lvl;
    } tlspq_slot_t;

    // summary of the chain seen by the controller
    typedef struct packed {
        tlspq_slot_t front;
        logic        second_valid;
        logic        found;
        logic        full;
    } tlspq_stat_t;

endpackage

// File: rtl/core/tlspq_cell.sv
module tlspq_cell
    import tlspq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  tlspq_op_t   op,
    input  tlspq_slot_t left_slot,
    input  logic        left_ge,
    input  tlspq_slot_t right_slot,
    input  logic        hit_in,
    output tlspq_slot_t slot,
    output logic        ge,
    output logic        hit_out
);

    logic             valid_reg, valid_next;
    logic [ID_W-1:0]  id_reg, id_next;
    logic [LVL_W-1:0] lvl_reg, lvl_next;

    assign slot = '{valid: valid_reg, id: id_reg, lvl: lvl_reg};

    // entry stays ahead of a new one of this level
    assign ge      = valid_reg && (lvl_reg >= op.lvl);
    // any match at or before this cell
    assign hit_out = hit_in | (valid_reg && (id_reg == op.key));

    // next content: keep, take new, or take a neighbor
    always_comb begin
        valid_next = valid_reg;
        id_next    = id_reg;
        lvl_next   = lvl_reg;
        case (op.mode)
            OP_INSERT: begin
                if (!ge) begin
                    if (left_ge) begin
                        valid_next = 1'b1;
                        id_next    = op.key;
                        lvl_next   = op.lvl;
                    end else begin
                        valid_next = left_slot.valid;
                        id_next    = left_slot.id;
                        lvl_next   = left_slot.lvl;
                    end
                end
            end
            OP_REMOVE: begin
                if (hit_out) begin
                    valid_next = right_slot.valid;
                    id_next    = right_slot.id;
                    lvl_next   = right_slot.lvl;
                end
            end
            OP_SHIFT: begin
                valid_next = right_slot.valid;
                id_next    = right_slot.id;
                lvl_next   = right_slot.lvl;
            end
            default: begin
                valid_next = valid_reg;
            end
        endcase
    end

    // valid bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        id_reg  <= id_next;
        lvl_reg <= lvl_next;
    end

endmodule

// File: rtl/core/tlspq_chain.sv
module tlspq_chain
    import tlspq_pkg::*;
#(
    parameter int DEPTH = TLSPQ_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  tlspq_op_t   op,
    output tlspq_stat_t stat
);

    tlspq_slot_t slots [DEPTH];
    logic        ge    [DEPTH];
    logic        hit   [DEPTH];

    localparam tlspq_slot_t SLOT_NONE = '{valid: 1'b0, id: '0, lvl: '0};

    // row of cells, sorted front to back
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        tlspq_slot_t l_slot, r_slot;
        logic        l_ge, h_in;
        if (i == 0) begin : g_head
            assign l_slot = SLOT_NONE;
            assign l_ge   = 1'b1;
            assign h_in   = 1'b0;
        end else begin : g_body
            assign l_slot = slots[i-1];
            assign l_ge   = ge[i-1];
            assign h_in   = hit[i-1];
        end
        if (i == DEPTH - 1) begin : g_tail
            assign r_slot = SLOT_NONE;
        end else begin : g_mid
            assign r_slot = slots[i+1];
        end
        tlspq_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .op        (op),
            .left_slot (l_slot),
            .left_ge   (l_ge),
            .right_slot(r_slot),
            .hit_in    (h_in),
            .slot      (slots[i]),
            .ge        (ge[i]),
            .hit_out   (hit[i])
        );
    end

    // summary for the controller
    assign stat.front        = slots[0];
    assign stat.second_valid = slots[1].valid;
    assign stat.found        = hit[DEPTH-1];
    assign stat.full         = slots[DEPTH-1].valid;

endmodule

// File: rtl/core/three_level_stable_priority_queue.sv
// Three-level stable priority queue built as a row of DEPTH cells.
// Request channel s_*: tdata holds cmd, key_id and priority_in. Insert puts
// the entry behind all entries of equal or higher level, update moves the
// first entry with key_id to a new level, drain streams the whole queue.
// Result channel m_*: tdata holds id_out, priority_out and status; tlast
// marks the final result of a request.
// Results: insert and the miss cases of update and drain load the result
// register when the request is taken. A found update removes the entry in
// the request cycle and reinserts it in state ST_INS once the result register
// is free, which also loads its result. A drain of n entries spends the
// request cycle to start, then emits one entry per cycle from the head cell
// while no stall on m_tready holds the result register.
// Requests: one at a time; s_tready stays low until an update or drain is
// complete. The cell row moves every entry at most one place per cycle.
// Reset clears the valid bit of every cell, so the queue starts empty.
// A stall on m_tready holds the result register; the queue then takes no new
// request and a drain pauses until the result is taken.
module three_level_stable_priority_queue
    import tlspq_pkg::*;
#(
    parameter int DEPTH = TLSPQ_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // cmd[1:0], key_id[11:2], priority_in[13:12]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // id_out[9:0], priority_out[11:10], status[13:12]
    output logic        m_tlast
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_INS   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [ID_W-1:0]   pend_key_reg, pend_key_next;
    logic [LVL_W-1:0]  pend_lvl_reg, pend_lvl_next;
    logic              m_valid_reg, m_valid_next;
    logic [ID_W-1:0]   id_out_reg, id_out_next;
    logic [LVL_W-1:0]  prio_out_reg, prio_out_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic              last_reg, last_next;

    logic [CMD_W-1:0]  in_cmd;
    logic [ID_W-1:0]   in_key;
    logic [LVL_W-1:0]  in_lvl;
    logic              out_free, req_acc, load;
    tlspq_op_t         op;
    tlspq_stat_t       chain_st;

    // request fields, level 0 taken as level 1
    assign in_cmd = s_tdata[1:0];
    assign in_key = s_tdata[11:2];
    assign in_lvl = (s_tdata[13:12] == '0) ? LVL_MIN : s_tdata[13:12];

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign req_acc  = s_tvalid && s_tready;

    tlspq_chain #(.DEPTH(DEPTH)) u_chain (
        .aclk   (aclk),
        .aresetn(aresetn),
        .op     (op),
        .stat   (chain_st)
    );

    // controller: cell operation, result and next state
    always_comb begin
        state_next    = state_reg;
        pend_key_next = pend_key_reg;
        pend_lvl_next = pend_lvl_reg;
        op.mode       = OP_HOLD;
        op.key        = (state_reg == ST_IDLE) ? in_key : pend_key_reg;
        op.lvl        = (state_reg == ST_IDLE) ? in_lvl : pend_lvl_reg;
        load          = 1'b0;
        id_out_next   = id_out_reg;
        prio_out_next = prio_out_reg;
        status_next   = status_reg;
        last_next     = last_reg;
        case (state_reg)
            ST_IDLE: begin
                if (req_acc) begin
                    case (in_cmd)
                        CMD_INSERT: begin
                            load        = 1'b1;
                            id_out_next = in_key;
                            last_next   = 1'b1;
                            if (chain_st.full) begin
                                prio_out_next = '0;
                                status_next   = STAT_FULL;
                            end else begin
                                op.mode       = OP_INSERT;
                                prio_out_next = in_lvl;
                                status_next   = STAT_OK;
                            end
                        end
                        CMD_UPDATE: begin
                            if (chain_st.found) begin
                                op.mode       = OP_REMOVE;
                                pend_key_next = in_key;
                                pend_lvl_next = in_lvl;
                                state_next    = ST_INS;
                            end else begin
                                load          = 1'b1;
                                id_out_next   = in_key;
                                prio_out_next = '0;
                                status_next   = STAT_NOTFOUND;
                                last_next     = 1'b1;
                            end
                        end
                        CMD_DRAIN: begin
                            if (chain_st.front.valid) begin
                                state_next = ST_DRAIN;
                            end else begin
                                load          = 1'b1;
                                id_out_next   = '0;
                                prio_out_next = '0;
                                status_next   = STAT_EMPTY;
                                last_next     = 1'b1;
                            end
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_INS: begin
                if (out_free) begin
                    op.mode       = OP_INSERT;
                    load          = 1'b1;
                    id_out_next   = pend_key_reg;
                    prio_out_next = pend_lvl_reg;
                    status_next   = STAT_OK;
                    last_next     = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_DRAIN: begin
                if (out_free) begin
                    op.mode       = OP_SHIFT;
                    load          = 1'b1;
                    id_out_next   = chain_st.front.id;
                    prio_out_next = chain_st.front.lvl;
                    status_next   = STAT_OK;
                    last_next     = !chain_st.second_valid;
                    if (!chain_st.second_valid) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        m_valid_next = load ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // pending update and result payload
    always_ff @(posedge aclk) begin
        pend_key_reg <= pend_key_next;
        pend_lvl_reg <= pend_lvl_next;
        id_out_reg   <= id_out_next;
        prio_out_reg <= prio_out_next;
        status_reg   <= status_next;
        last_reg     <= last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, status_reg, prio_out_reg, id_out_reg};
    assign m_tlast  = last_reg;

    // a reinsert always has a free cell
    a_ins_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_INS) |-> !chain_st.full)
        else $error("reinsert with full queue");

    // final drain result leaves the queue empty
    a_drain_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAIN && load && last_next) |=> !chain_st.front.valid)
        else $error("queue not empty after drain");

    // an ok result always carries a stored level
    a_ok_level: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && status_reg == STAT_OK) |-> (prio_out_reg != '0))
        else $error("ok result without level");

endmodule
